// ===== hdl/date_string_validator_top_assert.svh =====
// Assertion macros for the date string validator.
`ifndef DATE_STRING_VALIDATOR_TOP_ASSERT_SVH
`define DATE_STRING_VALIDATOR_TOP_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define DSV_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled in reset.
`define DSV_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/dsv_pkg.sv =====
// Shared types, constants and helper functions of the date string validator.
`timescale 1ns / 1ps
package dsv_pkg;

   localparam int QUEUE_DEPTH_DEFAULT = 2;

   localparam logic [7:0] CHAR_SLASH = 8'h2F;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;

   localparam logic [1:0] FIELD_DAY   = 2'd0;
   localparam logic [1:0] FIELD_MONTH = 2'd1;
   localparam logic [1:0] FIELD_YEAR  = 2'd2;
   localparam logic [1:0] FIELD_DONE  = 2'd3;

   localparam logic [6:0]  DAY_CAP    = 7'd99;
   localparam logic [13:0] YEAR_CAP   = 14'd9999;
   localparam logic [4:0]  YEAR_CAP_MOD25 = 5'd24;

   localparam logic [13:0] PIVOT_NEW_MAX = 14'd18;
   localparam logic [13:0] PIVOT_OLD_MAX = 14'd99;
   localparam logic [13:0] CENTURY_NEW   = 14'd2000;
   localparam logic [13:0] CENTURY_OLD   = 14'd1900;

   localparam logic [6:0] MONTH_FEB = 7'd2;
   localparam logic [6:0] MONTH_APR = 7'd4;
   localparam logic [6:0] MONTH_JUN = 7'd6;
   localparam logic [6:0] MONTH_SEP = 7'd9;
   localparam logic [6:0] MONTH_NOV = 7'd11;
   localparam logic [6:0] MONTH_MAX = 7'd12;
   localparam logic [6:0] DAY_MAX_LONG  = 7'd31;
   localparam logic [6:0] DAY_MAX_SHORT = 7'd30;
   localparam logic [6:0] DAY_MAX_LEAP  = 7'd29;
   localparam logic [6:0] DAY_MAX_FEB   = 7'd28;

   // One parsed date on its way from the parser to the checker.
   typedef struct packed {
      logic [6:0]  day;
      logic [6:0]  month;
      logic [13:0] year;
      logic [4:0]  year_mod25;
   } date_rec_type;

   function automatic logic [6:0] acc_day(input logic [6:0] v, input logic [3:0] d);
      logic [9:0] n;
      n = ({3'b0, v} << 3) + ({3'b0, v} << 1) + {6'b0, d};
      acc_day = (n > {3'b0, DAY_CAP}) ? DAY_CAP : n[6:0];
   endfunction

   function automatic logic [13:0] acc_year(input logic [13:0] v, input logic [3:0] d);
      logic [16:0] n;
      n = ({3'b0, v} << 3) + ({3'b0, v} << 1) + {13'b0, d};
      acc_year = (n > {3'b0, YEAR_CAP}) ? YEAR_CAP : n[13:0];
   endfunction

   // (r*10 + d) mod 25, quotient by reciprocal 41/1024 (exact for t < 250)
   function automatic logic [4:0] step_mod25(input logic [4:0] r, input logic [3:0] d);
      logic [7:0]  t;
      logic [13:0] p;
      logic [3:0]  q;
      logic [7:0]  rem;
      t   = ({3'b0, r} << 3) + ({3'b0, r} << 1) + {4'b0, d};
      p   = {6'b0, t} * 14'd41;
      q   = p[13:10];
      rem = t - (({4'b0, q} << 4) + ({4'b0, q} << 3) + {4'b0, q});
      step_mod25 = rem[4:0];
   endfunction

endpackage

// ===== hdl/dsv_parse.sv =====
// Front end: splits the character stream into day, month and year fields.
`timescale 1ns / 1ps
module dsv_parse (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 beat_in,
   input  logic [7:0]           char_code,
   input  logic                 last_char,
   output logic                 rec_push,
   output dsv_pkg::date_rec_type rec
);
   import dsv_pkg::*;

   logic [1:0]  field_ff, field_in;
   logic [6:0]  day_ff, day_in;
   logic [6:0]  month_ff, month_in;
   logic [13:0] year_ff, year_in;
   logic [4:0]  ymod_ff, ymod_in;
   logic        ended_ff, ended_in;

   logic        is_slash;
   logic        is_digit;
   logic [3:0]  digit;
   logic [13:0] year_acc;

   assign is_slash = (char_code == CHAR_SLASH);
   assign is_digit = (char_code >= CHAR_ZERO) && (char_code <= CHAR_NINE);
   assign digit    = char_code[3:0];
   assign year_acc = acc_year(year_ff, digit);

   always_comb begin
      field_in = field_ff;
      day_in   = day_ff;
      month_in = month_ff;
      year_in  = year_ff;
      ymod_in  = ymod_ff;
      ended_in = ended_ff;
      if (field_ff != FIELD_DONE) begin
         priority if (is_slash) begin
            field_in = field_ff + 2'd1;
            ended_in = 1'b0;
         end else if (!ended_ff && is_digit) begin
            unique case (field_ff)
               FIELD_DAY:   day_in = acc_day(day_ff, digit);
               FIELD_MONTH: month_in = acc_day(month_ff, digit);
               default: begin
                  year_in = year_acc;
                  ymod_in = (year_acc == YEAR_CAP) ? YEAR_CAP_MOD25
                                                   : step_mod25(ymod_ff, digit);
               end
            endcase
         end else begin
            ended_in = 1'b1;
         end
      end
   end

   assign rec_push       = beat_in && last_char;
   assign rec.day        = day_in;
   assign rec.month      = month_in;
   assign rec.year       = year_in;
   assign rec.year_mod25 = ymod_in;

   always_ff @(posedge clock) begin
      if (reset || rec_push) begin
         field_ff <= FIELD_DAY;
         day_ff   <= '0;
         month_ff <= '0;
         year_ff  <= '0;
         ymod_ff  <= '0;
         ended_ff <= 1'b0;
      end else if (beat_in) begin
         field_ff <= field_in;
         day_ff   <= day_in;
         month_ff <= month_in;
         year_ff  <= year_in;
         ymod_ff  <= ymod_in;
         ended_ff <= ended_in;
      end
   end

endmodule

// ===== hdl/dsv_queue.sv =====
// Small queue of parsed dates between the parser and the checker.
`timescale 1ns / 1ps
module dsv_queue #(
   parameter int DEPTH = dsv_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  dsv_pkg::date_rec_type wr_rec,
   output logic                  full,
   input  logic                  pop,
   output dsv_pkg::date_rec_type rd_rec,
   output logic                  empty
);
   import dsv_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   date_rec_type     mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_rec  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      unique case ({do_push, do_pop})
         2'b10:   count_in = count_ff + CNT_W'(1);
         2'b01:   count_in = count_ff - CNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wr_rec;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== hdl/dsv_check.sv =====
// Back end: year pivot, calendar check and the result register.
`timescale 1ns / 1ps
module dsv_check (
   input  logic                  clock,
   input  logic                  reset,
   input  dsv_pkg::date_rec_type rec,
   input  logic                  rec_avail,
   output logic                  rec_take,
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output logic                  rsp_date_valid
);
   import dsv_pkg::*;

   logic        valid_ff;
   logic        data_ff, data_in;
   logic [13:0] year;
   logic        leap;
   logic [6:0]  day_max;

   always_comb begin
      priority if (rec.year <= PIVOT_NEW_MAX) begin
         year = rec.year + CENTURY_NEW;
      end else if (rec.year <= PIVOT_OLD_MAX) begin
         year = rec.year + CENTURY_OLD;
      end else begin
         year = rec.year;
      end
   end

   // pivot offsets are multiples of 25, so the tracked residue still holds
   assign leap = ((year[3:0] == 4'd0) && (rec.year_mod25 == 5'd0))
              || ((year[1:0] == 2'd0) && (rec.year_mod25 != 5'd0));

   always_comb begin
      priority if (rec.month == MONTH_FEB) begin
         day_max = leap ? DAY_MAX_LEAP : DAY_MAX_FEB;
      end else if (rec.month == MONTH_APR || rec.month == MONTH_JUN
                   || rec.month == MONTH_SEP || rec.month == MONTH_NOV) begin
         day_max = DAY_MAX_SHORT;
      end else begin
         day_max = DAY_MAX_LONG;
      end
      data_in = (rec.month != 7'd0) && (rec.month <= MONTH_MAX)
             && (rec.day != 7'd0) && (rec.day <= day_max);
   end

   assign rec_take       = rec_avail && (!valid_ff || rsp_pop);
   assign rsp_empty      = !valid_ff;
   assign rsp_date_valid = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (rec_take) begin
         valid_ff <= 1'b1;
      end else if (rsp_pop) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rec_take) begin
         data_ff <= data_in;
      end
   end

endmodule

// ===== hdl/date_string_validator_top.sv =====
// Top level of the date string validator.
`timescale 1ns / 1ps
// Takes a d/m/y date string one character per beat and, on the beat marked
// last, queues that date for one validity flag. A character is taken every
// cycle while the queue has room. The parser hands each finished date to a
// QUEUE_DEPTH-entry queue on the edge that takes its last character. The
// checker registers the queue head as a result once its result register is
// empty or being popped. The input reports full only while that queue is full.
module date_string_validator_top #(
   parameter int QUEUE_DEPTH = dsv_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   output logic       req_full,
   input  logic [7:0] req_char_code,
   input  logic       req_last_char,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic       rsp_date_valid
);
   import dsv_pkg::*;
`include "date_string_validator_top_assert.svh"

   date_rec_type wr_rec;
   date_rec_type rd_rec;
   logic         beat_in;
   logic         q_push;
   logic         q_full;
   logic         q_empty;
   logic         q_pop;

   assign req_full = q_full;
   assign beat_in  = req_push && !q_full;

   dsv_parse u_parse (
      .clock     (clock),
      .reset     (reset),
      .beat_in   (beat_in),
      .char_code (req_char_code),
      .last_char (req_last_char),
      .rec_push  (q_push),
      .rec       (wr_rec)
   );

   dsv_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (q_push),
      .wr_rec (wr_rec),
      .full   (q_full),
      .pop    (q_pop),
      .rd_rec (rd_rec),
      .empty  (q_empty)
   );

   dsv_check u_check (
      .clock          (clock),
      .reset          (reset),
      .rec            (rd_rec),
      .rec_avail      (!q_empty),
      .rec_take       (q_pop),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_date_valid (rsp_date_valid)
   );

   `DSV_ASSERT_NEXT(a_queue_drains, clock, reset, (!q_empty && rsp_empty), !rsp_empty, "queued date not moved to result")
   `DSV_ASSERT_IMPLY(a_result_kept, clock, reset, $rose(rsp_empty), $past(rsp_pop), "result dropped without pop")
   `DSV_ASSERT_NEXT(a_last_queued, clock, reset, (beat_in && req_last_char && q_empty && rsp_empty), !q_empty, "last char produced no date")

endmodule

// ===== sim/date_string_validator_top_tb.sv =====
// Testbench of the date string validator: directed and random date strings, checked beat by beat.
`timescale 1ns / 1ps

class date_scoreboard;
   logic [1:0]  field_sel;
   logic [6:0]  day_acc;
   logic [6:0]  month_acc;
   logic [13:0] year_acc;
   logic        field_stopped;
   bit          flags_due[$];
   int          n_errors;

   function new();
      clear_date();
      n_errors = 0;
   endfunction

   function void clear_date();
      field_sel     = dsv_pkg::FIELD_DAY;
      day_acc       = '0;
      month_acc     = '0;
      year_acc      = '0;
      field_stopped = 1'b0;
   endfunction

   function int grow(int v, int digit, int cap);
      int n;
      n = v * 10 + digit;
      return (n > cap) ? cap : n;
   endfunction

   function bit calendar_ok();
      int y;
      bit leap;
      y = year_acc;
      if (y <= dsv_pkg::PIVOT_NEW_MAX) y += dsv_pkg::CENTURY_NEW;
      else if (y <= dsv_pkg::PIVOT_OLD_MAX) y += dsv_pkg::CENTURY_OLD;
      leap = (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
      if (month_acc < 1 || month_acc > dsv_pkg::MONTH_MAX) return 1'b0;
      if (day_acc < 1 || day_acc > dsv_pkg::DAY_MAX_LONG) return 1'b0;
      if ((month_acc == dsv_pkg::MONTH_APR || month_acc == dsv_pkg::MONTH_JUN ||
           month_acc == dsv_pkg::MONTH_SEP || month_acc == dsv_pkg::MONTH_NOV) &&
          day_acc > dsv_pkg::DAY_MAX_SHORT) return 1'b0;
      if (month_acc == dsv_pkg::MONTH_FEB &&
          day_acc > (leap ? dsv_pkg::DAY_MAX_LEAP : dsv_pkg::DAY_MAX_FEB)) return 1'b0;
      return 1'b1;
   endfunction

   // One accepted input beat.
   function void note_char(logic [7:0] ch, logic last);
      int digit;
      if (field_sel != dsv_pkg::FIELD_DONE) begin
         if (ch == dsv_pkg::CHAR_SLASH) begin
            field_sel     = field_sel + 2'd1;
            field_stopped = 1'b0;
         end else if (!field_stopped && ch >= dsv_pkg::CHAR_ZERO &&
                      ch <= dsv_pkg::CHAR_NINE) begin
            digit = ch - dsv_pkg::CHAR_ZERO;
            case (field_sel)
               dsv_pkg::FIELD_DAY: begin
                  day_acc = 7'(grow(day_acc, digit, dsv_pkg::DAY_CAP));
               end
               dsv_pkg::FIELD_MONTH: begin
                  month_acc = 7'(grow(month_acc, digit, dsv_pkg::DAY_CAP));
               end
               default: begin
                  year_acc = 14'(grow(year_acc, digit, dsv_pkg::YEAR_CAP));
               end
            endcase
         end else begin
            field_stopped = 1'b1;
         end
      end
      if (last) begin
         flags_due.push_back(calendar_ok());
         clear_date();
      end
   endfunction

   // One accepted result beat.
   function void check_flag(logic date_valid);
      bit due;
      if (flags_due.size() == 0) begin
         $error("unexpected result beat: date_valid=%0b", date_valid);
         n_errors++;
      end else begin
         due = flags_due.pop_front();
         if (date_valid !== due) begin
            $error("date_valid: expected %0b, actual %0b", due, date_valid);
            n_errors++;
         end
      end
   endfunction
endclass

module date_string_validator_top_tb;
   localparam int QUIET_LIMIT  = 3000;
   localparam int PHASE_CHARS  = 110;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_push = 1'b0;
   logic       req_full;
   logic [7:0] req_char_code = 8'h00;
   logic       req_last_char = 1'b0;
   logic       rsp_empty;
   logic       rsp_pop = 1'b0;
   logic       rsp_date_valid;

   date_scoreboard sb = new();
   logic [7:0] line_q[$];
   int tx_idle_pct = 0;
   int rx_stall_pct = 0;
   int rx_hold_left = 0;
   int chars_sent = 0;
   int quiet_cycles = 0;

   date_string_validator_top uut (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_char_code  (req_char_code),
      .req_last_char  (req_last_char),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_date_valid (rsp_date_valid)
   );

   always #6 clock = ~clock;

   always @(negedge clock) begin
      if (rx_hold_left > 0) begin
         rx_hold_left--;
         rsp_pop <= 1'b0;
      end else begin
         rsp_pop <= ($urandom_range(99) >= rx_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_pop && !rsp_empty) sb.check_flag(rsp_date_valid);
   end

   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_beat(input logic [7:0] ch, input logic last);
      while ($urandom_range(99) < tx_idle_pct) begin
         @(negedge clock);
         req_push <= 1'b0;
      end
      @(negedge clock);
      req_push      <= 1'b1;
      req_char_code <= ch;
      req_last_char <= last;
      do @(posedge clock); while (req_full);
      sb.note_char(ch, last);
      chars_sent++;
   endtask

   task automatic send_line();
      foreach (line_q[i]) send_beat(line_q[i], i == line_q.size() - 1);
      line_q.delete();
   endtask

   task automatic add_text(input string s);
      for (int i = 0; i < s.len(); i++) line_q.push_back(s[i]);
   endtask

   task automatic send_text(input string s);
      add_text(s);
      send_line();
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_push <= 1'b0;
      while (sb.flags_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic add_random_line();
      int d;
      int m;
      int y;
      int pos;
      if ($urandom_range(99) < 12) begin
         // raw noise over the whole byte range
         repeat ($urandom_range(1, 10)) line_q.push_back(8'($urandom_range(255)));
         return;
      end
      case ($urandom_range(4))
         0: d = $urandom_range(1, 31);
         1: d = $urandom_range(28, 31);
         2: d = $urandom_range(0, 40);
         3: d = $urandom_range(0, 150);
         default: d = $urandom_range(0, 99999);
      endcase
      case ($urandom_range(3))
         0: m = $urandom_range(1, 12);
         1: m = 2;
         2: m = 4 + 2 * $urandom_range(0, 1) + 5 * $urandom_range(0, 1);
         default: m = $urandom_range(0, 20);
      endcase
      case ($urandom_range(5))
         0: y = $urandom_range(0, 99);
         1: y = $urandom_range(1890, 2110);
         2: y = 1900 + 100 * $urandom_range(0, 5);
         3: y = -1;
         4: y = $urandom_range(0, 999999);
         default: y = 4 * $urandom_range(0, 30);
      endcase
      if ($urandom_range(7) == 0) add_text("0");
      add_text($sformatf("%0d/%0d/", d, m));
      if (y >= 0) add_text($sformatf("%0d", y));
      if ($urandom_range(9) == 0) begin
         add_text("/");
         repeat ($urandom_range(0, 4)) line_q.push_back(8'($urandom_range(255)));
      end
      if ($urandom_range(4) == 0) begin
         pos = $urandom_range(0, line_q.size() - 1);
         if ($urandom_range(1)) line_q[pos] = 8'($urandom_range(255));
         else line_q.insert(pos, 8'($urandom_range(255)));
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_text("29/2/2000");
      send_text("29/2/1900");
      send_text("29/2/2100");
      send_text("29/2/2400");
      send_text("29/2/04");
      send_text("29/2/19");
      send_text("28/2/01");
      send_text("31/4/2020");
      send_text("30/4/20");
      send_text("31/11/00");
      send_text("31/12/99");
      send_text("1/1/18");
      send_text("0/1/00");
      send_text("1/0/00");
      send_text("1/13/00");
      send_text("32/1/00");
      send_text("99999/1/2000");
      send_text("1/99999/2000");
      send_text("1/1/123456");
      send_text("29/2/99999");
      send_text("1/1/");
      send_text("1/1/2000/xyz/7");
      send_text(" 5/1/2000");
      send_text("5x7/1-2/2000");
      send_text("/");
      send_text("7");
      wait_drained();

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
            1: begin tx_idle_pct = 63; rx_stall_pct = 0;  end
            2: begin tx_idle_pct = 0;  rx_stall_pct = 63; end
            default: begin tx_idle_pct = 9; rx_stall_pct = 9; end
         endcase
         // long receiver hold-off so the date queue backs up onto the input
         if (phase == 0) rx_hold_left = 300;
         chars_sent = 0;
         while (chars_sent < PHASE_CHARS) begin
            add_random_line();
            send_line();
         end
         wait_drained();
      end

      if (sb.n_errors == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end
endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/dsv_pkg.sv
hdl/dsv_parse.sv
hdl/dsv_queue.sv
hdl/dsv_check.sv
hdl/date_string_validator_top.sv
sim/date_string_validator_top_tb.sv
